[sv/hcd_pkg.sv]
// Shared types and constants for the chunked body decoder.
// No dependencies; imported by every module of the block.
package hcd_pkg;

    // Width of the chunk size and remaining-byte counter
    localparam int LEN_BITS = 32;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Framing characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HI = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [3:0] HEX_TEN  = 4'ha;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_BADCHAR  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       body_start;
    } t_in;

    typedef struct packed {
        logic [7:0] payload_byte;
        t_kind      result_kind;
    } t_out;

    // Queue status seen by the top level and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[sv/hcd_front.sv]
// Front end: parses chunk framing one byte per transfer and pushes results.
// Depends on hcd_pkg.
module hcd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  hcd_pkg::t_in  i_item,
    output logic          o_push,
    output hcd_pkg::t_out o_res
);
    import hcd_pkg::*;

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_SKIP_ONE   = 3'd1,
        PH_SIZE       = 3'd2,
        PH_EXT        = 3'd3,
        PH_WAIT_LF    = 3'd4,
        PH_DATA       = 3'd5,
        PH_DONE       = 3'd6
    } t_phase;

    t_phase              r_phase, n_phase, cur_phase;
    logic [LEN_BITS-1:0] r_rem, n_rem, cur_rem;
    logic [7:0]          c;
    logic                is_hex;
    logic [3:0]          hex_val;
    logic                size_push;
    t_kind               size_kind;
    t_phase              size_phase;
    logic [LEN_BITS-1:0] size_rem;

    assign c = i_item.data_byte;

    // Clear state ahead of the first byte of a new body
    assign cur_phase = i_item.body_start ? PH_LINE_START : r_phase;
    assign cur_rem   = i_item.body_start ? '0 : r_rem;

    // Decode one hex digit
    always_comb begin
        is_hex  = 1'b1;
        hex_val = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            hex_val = 4'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LF_HI) begin
            hex_val = HEX_TEN + 4'(c - CH_LA);
        end else if (c >= CH_UA && c <= CH_UF) begin
            hex_val = HEX_TEN + 4'(c - CH_UA);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Handle a byte of the size digits
    always_comb begin
        size_push  = 1'b0;
        size_kind  = KIND_BADCHAR;
        size_phase = PH_DONE;
        size_rem   = cur_rem;
        if (is_hex) begin
            if (cur_rem[LEN_BITS-1 -: 4] != 4'd0) begin
                size_push = 1'b1;
                size_kind = KIND_OVERFLOW;
            end else begin
                size_rem   = {cur_rem[LEN_BITS-5:0], hex_val};
                size_phase = PH_SIZE;
            end
        end else if (c == CH_SEMI) begin
            size_phase = PH_EXT;
        end else if (c == CH_CR) begin
            size_phase = PH_WAIT_LF;
        end else begin
            size_push = 1'b1;
        end
    end

    // Advance the framing state
    always_comb begin
        n_phase = cur_phase;
        n_rem   = cur_rem;
        o_push  = 1'b0;
        o_res   = '{payload_byte: 8'd0, result_kind: KIND_PAYLOAD};
        case (cur_phase)
            PH_LINE_START: begin
                if (c == CH_CR) begin
                    n_phase = PH_SKIP_ONE;
                end else begin
                    n_phase           = size_phase;
                    n_rem             = size_rem;
                    o_push            = size_push;
                    o_res.result_kind = size_kind;
                end
            end
            PH_SKIP_ONE: n_phase = PH_SIZE;
            PH_SIZE: begin
                n_phase           = size_phase;
                n_rem             = size_rem;
                o_push            = size_push;
                o_res.result_kind = size_kind;
            end
            PH_EXT: begin
                if (c == CH_CR) n_phase = PH_WAIT_LF;
            end
            PH_WAIT_LF: begin
                if (c == CH_LF) begin
                    if (cur_rem == '0) begin
                        n_phase           = PH_DONE;
                        o_push            = 1'b1;
                        o_res.result_kind = KIND_COMPLETE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_rem              = cur_rem - 1'b1;
                o_push             = 1'b1;
                o_res.payload_byte = c;
                if (cur_rem == LEN_BITS'(1)) n_phase = PH_LINE_START;
            end
            default: n_phase = PH_DONE;
        endcase
        o_push = o_push & i_accept;
    end

    // Hold state between transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE_START;
            r_rem   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
        end
    end

endmodule

[sv/hcd_queue.sv]
// Short result queue between the front and the back.
// Depends on hcd_pkg.
module hcd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hcd_pkg::t_out    i_data,
    input  logic             i_pop,
    output hcd_pkg::t_out    o_data,
    output hcd_pkg::t_q_stat o_stat
);
    import hcd_pkg::*;

    t_out          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/hcd_back.sv]
// Back end: output register that drains the result queue.
// Depends on hcd_pkg.
module hcd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hcd_pkg::t_q_stat i_stat,
    input  hcd_pkg::t_out    i_data,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output hcd_pkg::t_out    o_data
);
    import hcd_pkg::*;

    logic r_valid;
    t_out r_data;

    // Pop when the output register is free or being taken
    assign o_pop   = !i_stat.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload on pop
    always_ff @(posedge i_clk) begin
        if (o_pop) r_data <= i_data;
    end

endmodule

[sv/http_chunked_body_decoder_top.sv]
// Top level of the chunked body decoder: front parser, queue, output stage.
// Depends on hcd_pkg, hcd_front, hcd_queue, hcd_back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_in_data   (t_in)
//  out     | source    | o_out_valid / i_out_ready  | o_out_data  (t_out)
//
// One byte is taken per clock while the result queue has room; each byte updates
// the framing state and yields zero or one result. A result is stored in the
// queue and then loaded into the output register. o_in_ready falls only when
// the four-entry result queue is full. Reset is synchronous, active low, and
// returns the parser to the start of a size line with a zero count.
module http_chunked_body_decoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hcd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hcd_pkg::t_out o_out_data
);
    import hcd_pkg::*;

    logic    accept;
    logic    push;
    logic    pop;
    t_out    front_res;
    t_out    q_data;
    t_q_stat q_stat;

    assign o_in_ready = !q_stat.full;
    assign accept     = i_in_valid && o_in_ready;

    hcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_res    (front_res)
    );

    hcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    hcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (q_stat),
        .i_data  (q_data),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[bench/tb.sv]
// Self-checking bench for http_chunked_body_decoder_top: directed and random bodies.
// Depends on hcd_pkg and the decoder RTL; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb;
    import hcd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 650;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 80;

    // Parser phases of the framing state machine
    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_SKIP_ONE,
        PH_SIZE,
        PH_EXT,
        PH_WAIT_LF,
        PH_DATA,
        PH_DONE
    } t_dec_phase;

    // Tracks the framing state and holds the decoded results still due
    class t_chunk_decoder_check;
        t_out                decoded_q[$];
        t_dec_phase          phase;
        logic [LEN_BITS-1:0] chunk_left;
        int unsigned         n_errors;
        int unsigned         n_results;

        function new();
            phase      = PH_LINE_START;
            chunk_left = '0;
            n_errors   = 0;
            n_results  = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
            logic [7:0] ofs;
            v = '0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                ofs = c - CH_ZERO;
                v   = ofs[3:0];
                return 1'b1;
            end
            if (c >= CH_LA && c <= CH_LF_HI) begin
                ofs = c - CH_LA;
                v   = HEX_TEN + ofs[3:0];
                return 1'b1;
            end
            if (c >= CH_UA && c <= CH_UF) begin
                ofs = c - CH_UA;
                v   = HEX_TEN + ofs[3:0];
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void add_result(logic [7:0] b, t_kind k);
            t_out r;
            r.payload_byte = b;
            r.result_kind  = k;
            decoded_q.push_back(r);
        endfunction

        // One byte of the size digits: accumulate, switch on ';' or CR, else error out
        function void size_char(logic [7:0] c);
            logic [3:0] d;
            if (hex_nibble(c, d)) begin
                if (chunk_left[LEN_BITS-1 -: 4] != '0) begin
                    phase = PH_DONE;
                    add_result(8'h00, KIND_OVERFLOW);
                end else begin
                    chunk_left = {chunk_left[LEN_BITS-5:0], d};
                    phase      = PH_SIZE;
                end
            end else if (c == CH_SEMI) begin
                phase = PH_EXT;
            end else if (c == CH_CR) begin
                phase = PH_WAIT_LF;
            end else begin
                phase = PH_DONE;
                add_result(8'h00, KIND_BADCHAR);
            end
        endfunction

        // Advance the framing state by one accepted byte
        function void decode_byte(t_in item);
            logic [7:0] c;
            c = item.data_byte;
            if (item.body_start) begin
                phase      = PH_LINE_START;
                chunk_left = '0;
            end
            case (phase)
                PH_LINE_START: begin
                    if (c == CH_CR) phase = PH_SKIP_ONE;
                    else size_char(c);
                end
                PH_SKIP_ONE: phase = PH_SIZE;
                PH_SIZE:     size_char(c);
                PH_EXT: begin
                    if (c == CH_CR) phase = PH_WAIT_LF;
                end
                PH_WAIT_LF: begin
                    if (c == CH_LF) begin
                        if (chunk_left == '0) begin
                            phase = PH_DONE;
                            add_result(8'h00, KIND_COMPLETE);
                        end else begin
                            phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    chunk_left = chunk_left - 1'b1;
                    if (chunk_left == '0) phase = PH_LINE_START;
                    add_result(c, KIND_PAYLOAD);
                end
                default: phase = PH_DONE;
            endcase
        endfunction

        task report(string msg);
            n_errors++;
            $display("[%0t] decode mismatch: %s", $time, msg);
        endtask

        // Compare one output transfer with the oldest decoded result
        task match_output(t_out got);
            t_out want;
            n_results++;
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected result kind=%0d byte=%h",
                                 got.result_kind, got.payload_byte));
                return;
            end
            want = decoded_q.pop_front();
            if (got.result_kind !== want.result_kind || got.payload_byte !== want.payload_byte)
                report($sformatf("result %0d: kind=%0d byte=%h, want kind=%0d byte=%h",
                                 n_results, got.result_kind, got.payload_byte,
                                 want.result_kind, want.payload_byte));
        endtask
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    t_chunk_decoder_check board = new();
    t_in         byte_feed[$];
    bit          start_next;
    int          n_ignored;
    bit          rx_hold;

    http_chunked_body_decoder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function void push_byte(logic [7:0] b);
        t_in item;
        item.data_byte  = b;
        item.body_start = start_next;
        start_next      = 1'b0;
        byte_feed.push_back(item);
    endfunction

    // Hex digit in random letter case
    function logic [7:0] hex_char(logic [3:0] n);
        if (n < HEX_TEN) return CH_ZERO + {4'h0, n};
        return (($urandom_range(0, 1) != 0) ? CH_UA : CH_LA) + {4'h0, n - HEX_TEN};
    endfunction

    function logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Bytes after the end of a body; the decoder drops them
    function void push_trailer();
        repeat ($urandom_range(0, 2)) begin
            push_byte(rand_byte());
            n_ignored++;
        end
    endfunction

    // Size line: optional leading CR pair, zeros, digits, extension, junk before LF
    function void push_size_line(int unsigned size, bit first);
        int unsigned nd;
        logic [7:0]  b;
        if (first && $urandom_range(0, 4) == 0) begin
            push_byte(CH_CR);
            push_byte(CH_LF);
        end
        if (!(size == 0 && !first && $urandom_range(0, 4) == 0)) begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(CH_ZERO);
            nd = 1;
            while ((size >> (4 * nd)) != 0) nd++;
            for (int k = nd - 1; k >= 0; k--) push_byte(hex_char(4'(size >> (4 * k))));
        end
        if ($urandom_range(0, 3) == 0) begin
            push_byte(CH_SEMI);
            repeat ($urandom_range(0, 4)) begin
                b = rand_byte();
                push_byte((b == CH_CR) ? CH_SEMI : b);
            end
        end
        push_byte(CH_CR);
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                b = rand_byte();
                push_byte((b == CH_LF) ? CH_SEMI : b);
            end
        end
        push_byte(CH_LF);
    endfunction

    // One non-empty chunk with random data and its closing CR and skipped byte
    function void push_chunk(bit first);
        int unsigned size;
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        push_size_line(size, first);
        repeat (size) push_byte(rand_byte());
        push_byte(CH_CR);
        push_byte(($urandom_range(0, 7) == 0) ? rand_byte() : CH_LF);
    endfunction

    function void gen_well_formed();
        int unsigned n_chunks;
        start_next = 1'b1;
        n_chunks   = $urandom_range(0, 3);
        for (int k = 0; k < n_chunks; k++) push_chunk(k == 0);
        push_size_line(0, n_chunks == 0);
        push_trailer();
    endfunction

    function void gen_bad_char();
        logic [7:0] b;
        logic [3:0] nib;
        start_next = 1'b1;
        if ($urandom_range(0, 1) != 0) push_chunk(1'b1);
        repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15))));
        do begin
            if ($urandom_range(0, 1) != 0) b = 8'($urandom_range(CH_LA + 6, CH_LA + 25));
            else b = rand_byte();
        end while (board.hex_nibble(b, nib) || b == CH_SEMI || b == CH_CR);
        push_byte(b);
        push_trailer();
    endfunction

    function void gen_overflow();
        start_next = 1'b1;
        if ($urandom_range(0, 1) != 0) push_chunk(1'b1);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(CH_ZERO);
        push_byte(hex_char(4'($urandom_range(1, 15))));
        repeat (LEN_BITS / 4 - 1) push_byte(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 2) == 0) begin
            // full-width size fits; a later body cuts the long chunk short
            push_byte(CH_CR);
            push_byte(CH_LF);
            repeat ($urandom_range(1, 5)) push_byte(rand_byte());
        end else begin
            push_byte(hex_char(4'($urandom_range(0, 15))));
            push_trailer();
        end
    endfunction

    function void gen_noise();
        logic [7:0] b;
        start_next = 1'b1;
        repeat ($urandom_range(1, 16)) begin
            if ($urandom_range(0, 7) == 0) start_next = 1'b1;
            case ($urandom_range(0, 4))
                0:       b = CH_CR;
                1:       b = CH_LF;
                2:       b = CH_SEMI;
                3:       b = hex_char(4'($urandom_range(0, 15)));
                default: b = rand_byte();
            endcase
            push_byte(b);
        end
    endfunction

    function void build_directed();
        // one-byte chunk carrying 0xFF, then a zero size with an empty extension
        start_next = 1'b1;
        push_byte("1");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(8'hff);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_ZERO);
        push_byte(CH_SEMI);
        push_byte(CH_CR);
        push_byte(CH_LF);
        // leading CR skips a zero byte, then a letter past 'f' is rejected
        start_next = 1'b1;
        push_byte(CH_CR);
        push_byte(8'h00);
        push_byte("g");
        // bare CR size line completes the body
        start_next = 1'b1;
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(CH_LF);
        // ninth digit carries the size past the counter width
        start_next = 1'b1;
        push_byte("F");
        repeat (LEN_BITS / 4 - 1) push_byte(CH_ZERO);
        push_byte("a");
    endfunction

    // ------------------------------------------------------------------
    // Input driver: hold valid and payload until the transfer
    // ------------------------------------------------------------------
    task automatic send_item(t_in item, int unsigned gap, bit drain);
        if (gap != 0 || drain) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain) begin
                @(posedge i_clk);
                while (board.pending() != 0) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Monitor both channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) board.match_output(o_out_data);
            if (i_in_valid && o_in_ready) board.decode_byte(i_in_data);
        end
    end

    // Result side: random stalls, bursts, and one long hold-off
    initial begin : result_sink
        int unsigned stall;
        int unsigned takes;
        bit          hold_done;
        bit          rx_burst;
        i_out_ready <= 1'b0;
        rx_hold   = 1'b0;
        hold_done = 1'b0;
        rx_burst  = 1'b0;
        takes     = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (takes % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            takes++;
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if (!hold_done && board.n_results >= HOLD_AFTER) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
                rx_hold   = 1'b1;
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rx_hold = 1'b0;
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // End the run when no transfer happens for too long
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("http_chunked_body_decoder_top verification failed");
        $finish;
    end

    // Reset, build the byte stream, drive it, then drain and judge
    initial begin : main_flow
        int          n_directed;
        int          drain_mid;
        int unsigned gap;
        int unsigned pick;
        bit          tx_burst;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        start_next = 1'b0;
        n_ignored  = 0;
        tx_burst   = 1'b0;

        build_directed();
        n_directed = byte_feed.size();
        while (byte_feed.size() - n_directed - n_ignored < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)      gen_well_formed();
            else if (pick < 16) gen_bad_char();
            else if (pick < 18) gen_overflow();
            else                gen_noise();
        end
        drain_mid = n_directed + (byte_feed.size() - n_directed) / 2;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < byte_feed.size(); i++) begin
            if (i % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
            gap = (tx_burst || rx_hold) ? 0 : $urandom_range(0, 13);
            send_item(byte_feed[i], gap, i == n_directed || i == drain_mid);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.n_errors == 0)
            $display("http_chunked_body_decoder_top verification clean");
        else
            $display("http_chunked_body_decoder_top verification failed");
        $finish;
    end

endmodule
